// ===== rtl/core/uer_pkg.sv =====
// Shared types, widths, register indexes and reset values for the echo ranger.
package uer_pkg;

  // Default width of the tick counter
  localparam int COUNT_BITS_DEF = 15;

  // Configuration register widths
  localparam int TRIG_W  = 8;
  localparam int TO_W    = 15;
  localparam int SCALE_W = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_TIMEOUT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_TIMEOUT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_PER_TICK = 2'd3;

  // Register reset values
  localparam logic [TRIG_W-1:0]  TRIGGER_TICKS_RST  = 8'd2;
  localparam logic [TO_W-1:0]    RISE_TIMEOUT_RST   = 15'd2000;
  localparam logic [TO_W-1:0]    ECHO_TIMEOUT_RST   = 15'd19000;
  localparam logic [SCALE_W-1:0] SCALE_PER_TICK_RST = 8'd17;

  // Result widths
  localparam int DIST_W      = 23;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_RISE = 2'd2,
    PH_MEAS = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_RISE  = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_t;

  typedef struct packed {
    logic [TRIG_W-1:0]  trigger_ticks;
    logic [TO_W-1:0]    rise_timeout;
    logic [TO_W-1:0]    echo_timeout;
    logic [SCALE_W-1:0] scale_per_tick;
  } cfg_t;

  typedef struct packed {
    logic              trigger;
    logic              busy;
    logic              done;
    status_t           status;
    logic [DIST_W-1:0] distance;
  } res_t;

endpackage

// ===== rtl/core/uer_cfg_regs.sv =====
// Configuration register bank of the echo ranger.
module uer_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output uer_pkg::cfg_t                  cfg
);
  import uer_pkg::*;

  // Write the addressed register, truncated to its width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_ticks  <= TRIGGER_TICKS_RST;
      cfg.rise_timeout   <= RISE_TIMEOUT_RST;
      cfg.echo_timeout   <= ECHO_TIMEOUT_RST;
      cfg.scale_per_tick <= SCALE_PER_TICK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRIGGER_TICKS:  cfg.trigger_ticks  <= cfg_wdata[TRIG_W-1:0];
        REG_RISE_TIMEOUT:   cfg.rise_timeout   <= cfg_wdata[TO_W-1:0];
        REG_ECHO_TIMEOUT:   cfg.echo_timeout   <= cfg_wdata[TO_W-1:0];
        REG_SCALE_PER_TICK: cfg.scale_per_tick <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/uer_ctrl.sv =====
// Measurement state machine, tick counter and distance calculation.
module uer_ctrl #(
  parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          tick,
  input  logic          start_req,
  input  logic          echo,
  input  uer_pkg::cfg_t cfg,
  output uer_pkg::res_t res
);
  import uer_pkg::*;

  localparam int CMP_W  = (COUNT_BITS > TO_W) ? COUNT_BITS : TO_W;
  localparam int PROD_W = COUNT_BITS + SCALE_W;
  localparam int EXT_W  = (PROD_W > DIST_W) ? PROD_W : DIST_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic [EXT_W-1:0]      DIST_MAX = EXT_W'({DIST_W{1'b1}});

  phase_t                phase;
  phase_t                phase_next;
  logic [COUNT_BITS-1:0] tick_count;
  logic [COUNT_BITS-1:0] tick_count_next;
  logic [COUNT_BITS-1:0] count_inc;
  logic                  cnt_full;
  logic                  rise_expired;
  logic                  echo_expired;
  logic                  trig_reached;
  logic [EXT_W-1:0]      prod;
  logic [DIST_W-1:0]     dist_sat;
  logic                  done;
  status_t               status;
  logic [DIST_W-1:0]     dist_out;

  // Counter compares; an all-ones counter counts as expired
  assign cnt_full     = (tick_count == CNT_MAX);
  assign count_inc    = cnt_full ? tick_count : tick_count + 1'b1;
  assign rise_expired = cnt_full || (CMP_W'(tick_count) >= CMP_W'(cfg.rise_timeout));
  assign echo_expired = cnt_full || (CMP_W'(tick_count) >= CMP_W'(cfg.echo_timeout));
  assign trig_reached = (CMP_W'(count_inc) >= CMP_W'(cfg.trigger_ticks));

  // Echo ticks times scale, saturated to the result width
  assign prod     = EXT_W'(tick_count) * EXT_W'(cfg.scale_per_tick);
  assign dist_sat = (prod > DIST_MAX) ? {DIST_W{1'b1}} : prod[DIST_W-1:0];

  // Hold phase and counter unless an item moves through
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= '0;
    end else if (en) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
    end
  end

  // Next phase, counter and result for the current item
  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    done            = 1'b0;
    status          = ST_OK;
    dist_out        = '0;
    case (phase)
      PH_IDLE: begin
        if (start_req) begin
          phase_next      = PH_TRIG;
          tick_count_next = '0;
        end
      end
      PH_TRIG: begin
        if (tick) begin
          if (trig_reached) begin
            phase_next      = PH_RISE;
            tick_count_next = '0;
          end else begin
            tick_count_next = count_inc;
          end
        end
      end
      PH_RISE: begin
        if (echo) begin
          phase_next      = PH_MEAS;
          tick_count_next = '0;
        end else if (tick) begin
          if (rise_expired) begin
            done   = 1'b1;
            status = ST_NO_RISE;
          end else begin
            tick_count_next = count_inc;
          end
        end
      end
      PH_MEAS: begin
        // A falling edge wins over the tick on the same item
        if (!echo) begin
          done     = 1'b1;
          dist_out = dist_sat;
        end else if (tick) begin
          if (echo_expired) begin
            done   = 1'b1;
            status = ST_TOO_LONG;
          end else begin
            tick_count_next = count_inc;
          end
        end
      end
      default: phase_next = PH_IDLE;
    endcase

    if (done) begin
      phase_next      = PH_IDLE;
      tick_count_next = '0;
    end

    res.trigger  = (phase_next == PH_TRIG);
    res.busy     = (phase_next != PH_IDLE);
    res.done     = done;
    res.status   = status;
    res.distance = dist_out;
  end

  a_done_idles: assert property (@(posedge clk) disable iff (rst)
    en && done |=> phase == PH_IDLE && tick_count == '0)
    else $error("measurement end did not return to idle");

  a_hold_no_item: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(phase) && $stable(tick_count))
    else $error("state moved without an item");

  a_status_only_on_done: assert property (@(posedge clk) disable iff (rst)
    !done |-> status == ST_OK && dist_out == '0)
    else $error("status or distance reported without measurement end");

  a_idle_needs_start: assert property (@(posedge clk) disable iff (rst)
    en && phase == PH_IDLE && !start_req |=> phase == PH_IDLE)
    else $error("left idle without a start request");

endmodule

// ===== rtl/core/ultrasonic_echo_ranger_core.sv =====
// Ultrasonic echo ranger: input register, measurement control and result register.
// The block takes one item per clock unless the result stream stalls: each item is
// one clock's tick strobe, start request and sampled echo level, and every item
// gives exactly one result showing the trigger level, busy flag, end-of-measurement
// flag, status and distance after that item. An accepted item passes through the
// input register, then the result register; a stall on the result stream holds it
// in the input register. The sustained rate is one item per cycle when unstalled,
// as the phase and tick counter update once per item. Distance is the echo-high
// tick count times scale_per_tick, in hundredths of a centimetre, saturating at the
// 23-bit maximum. Configuration is written through a plain write port; the user
// must write it only while the block is idle, as the block does not enforce this.
module ultrasonic_echo_ranger_core #(
  parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [uer_pkg::IN_TDATA_W-1:0]  s_tdata,  // [0] tick, [1] start_req, [2] echo
  // Result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [uer_pkg::OUT_TDATA_W-1:0] m_tdata,  // [0] trigger, [1] busy_res,
                                                    // [2] done_res, [4:3] status,
                                                    // [27:5] distance_centi_cm
  // Configuration write port
  input  logic                            cfg_we,
  input  logic [uer_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import uer_pkg::*;

  cfg_t cfg;
  res_t res;
  logic in_valid;
  logic in_tick;
  logic in_start;
  logic in_echo;
  logic adv;
  res_t out_res;

  uer_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Move the held item on when the result register is free or being drained
  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_tick  <= s_tdata[0];
      in_start <= s_tdata[1];
      in_echo  <= s_tdata[2];
    end
  end

  uer_ctrl #(
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .tick      (in_tick),
    .start_req (in_start),
    .echo      (in_echo),
    .cfg       (cfg),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res <= res;
    end
  end

  // Pack result fields, lowest first
  assign m_tdata = {{(OUT_TDATA_W - DIST_W - 5){1'b0}}, out_res.distance,
                    out_res.status, out_res.done, out_res.busy, out_res.trigger};

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !adv |=> in_valid && $stable(in_tick) && $stable(in_start) &&
                         $stable(in_echo))
    else $error("held input item lost while result register stalled");

  a_result_after_adv: assert property (@(posedge clk) disable iff (rst)
    adv |=> m_tvalid)
    else $error("advanced item produced no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !adv)
    else $error("pending result overwritten");

endmodule
